// ----- src/mbe_pkg.sv -----
package mbe_pkg;

   localparam int FRAC           = 28;
   localparam int MAX_ITER_DEF   = 8192;
   localparam int COORD_BITS_DEF = 10;

   localparam int CFG_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int COUNT_W = 13;
   localparam int SHADE_W = 4;
   localparam int GLYPH_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_RE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IM   = 2'd3;

   localparam logic signed [31:0] ORIGIN_RE_RST = -32'sd536870912;
   localparam logic signed [31:0] ORIGIN_IM_RST = -32'sd536870912;
   localparam logic [30:0]        STEP_RE_RST   = 31'd13421773;
   localparam logic [30:0]        STEP_IM_RST   = 31'd26843546;

   localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;

   // ".,'\"-+onm$#Q0BNM"
   localparam logic [GLYPH_W-1:0] SHADE_GLYPHS [16] = '{
      8'h2E, 8'h2C, 8'h27, 8'h22, 8'h2D, 8'h2B, 8'h6F, 8'h6E,
      8'h6D, 8'h24, 8'h23, 8'h51, 8'h30, 8'h42, 8'h4E, 8'h4D
   };

   typedef struct packed {
      logic accept;
      logic map;
      logic mul;
      logic add;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   // floor(log2(c)), zero for zero
   function automatic logic [SHADE_W-1:0] shade_of(logic [COUNT_W-1:0] c);
      logic [SHADE_W-1:0] s;
      s = '0;
      for (int i = 0; i < COUNT_W; i++) begin
         if (c[i]) begin
            s = SHADE_W'(i);
         end
      end
      return s;
   endfunction

endpackage

// ----- src/mbe_ifs.sv -----
interface mbe_req_if #(
   parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_col;
   logic [COORD_BITS-1:0] pixel_row;

   modport source (output valid, output pixel_col, output pixel_row, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mbe_pkg::COUNT_W-1:0]  escape_count;
   logic [mbe_pkg::SHADE_W-1:0]  shade_level;
   logic [mbe_pkg::GLYPH_W-1:0]  glyph;

   modport source (output valid, output escape_count, output shade_level, output glyph,
                   input ready);
   modport sink   (input valid, input escape_count, input shade_level, input glyph,
                   output ready);
endinterface

// ----- src/mbe_ctrl.sv -----
module mbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mbe_pkg::status_type  status,
   output mbe_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAP  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = status.done ? ST_FIN : ST_MUL;
         end
         ST_FIN: begin
            // hold the count until the output register frees up
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/mbe_dpath.sv -----
module mbe_dpath #(
   parameter int MAX_ITER   = mbe_pkg::MAX_ITER_DEF,
   parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  logic [mbe_pkg::CFG_W-1:0]           csr_wdata,
   input  logic [COORD_BITS-1:0]               pixel_col,
   input  logic [COORD_BITS-1:0]               pixel_row,
   input  mbe_pkg::cmd_type                    cmd,
   output mbe_pkg::status_type                 status,
   output logic [mbe_pkg::COUNT_W-1:0]         escape_count,
   output logic [mbe_pkg::SHADE_W-1:0]         shade_level,
   output logic [mbe_pkg::GLYPH_W-1:0]         glyph
);

   localparam int KW = $clog2(MAX_ITER + 1);
   localparam int PW = COORD_BITS + 31;
   localparam int SW = PW + 2;
   localparam int NW = 36;
   localparam logic signed [NW-1:0] TWO_Q  = NW'(64'sd2 <<< mbe_pkg::FRAC);
   localparam logic signed [NW-1:0] NTWO_Q = -TWO_Q;
   localparam logic signed [63:0]   FOUR_Q56 = 64'sd4 <<< (2 * mbe_pkg::FRAC);

   // configuration
   logic signed [31:0] origin_re_ff, origin_im_ff;
   logic [30:0]        step_re_ff, step_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= mbe_pkg::ORIGIN_RE_RST;
         origin_im_ff <= mbe_pkg::ORIGIN_IM_RST;
         step_re_ff   <= mbe_pkg::STEP_RE_RST;
         step_im_ff   <= mbe_pkg::STEP_IM_RST;
      end else if (csr_we) begin
         unique case (csr_idx)
            mbe_pkg::CSR_ORIGIN_RE: origin_re_ff <= csr_wdata;
            mbe_pkg::CSR_ORIGIN_IM: origin_im_ff <= csr_wdata;
            mbe_pkg::CSR_STEP_RE:   step_re_ff   <= csr_wdata[30:0];
            mbe_pkg::CSR_STEP_IM:   step_im_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // pixel to point: multiply on accept, add and saturate next cycle
   logic [PW-1:0] col_prod_ff, row_prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_prod_ff <= PW'(pixel_col) * PW'(step_re_ff);
         row_prod_ff <= PW'(pixel_row) * PW'(step_im_ff);
      end
   end

   function automatic logic signed [31:0] sat_point(logic signed [31:0] org,
                                                   logic [PW-1:0] prod);
      logic signed [SW-1:0] sum;
      logic                 all_one, all_zero;
      sum      = SW'(org) + $signed({2'b00, prod});
      all_one  = &sum[SW-1:31];
      all_zero = ~|sum[SW-1:31];
      if (all_one || all_zero) begin
         return sum[31:0];
      end
      return sum[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // iteration state
   logic signed [31:0] cr_ff, ci_ff;
   logic signed [31:0] zr_ff, zi_ff;
   logic [KW-1:0]      k_ff;
   logic signed [63:0] prr_ff, pii_ff, pri_ff;
   logic [mbe_pkg::COUNT_W-1:0] res_ff;

   logic signed [63:0] sumsq;
   logic signed [NW-1:0] nr, ni;
   logic               esc_sum, esc_range, at_limit;
   logic [KW-1:0]      hit_idx;
   logic [KW-1:0]      fin_idx;

   always_comb begin
      sumsq     = prr_ff + pii_ff;
      // z from the previous round is checked here, one round late
      esc_sum   = sumsq > FOUR_Q56;
      nr        = NW'(prr_ff >>> mbe_pkg::FRAC) - NW'(pii_ff >>> mbe_pkg::FRAC) + NW'(cr_ff);
      ni        = NW'(pri_ff >>> (mbe_pkg::FRAC - 1)) + NW'(ci_ff);
      esc_range = (nr > TWO_Q) || (nr < NTWO_Q) || (ni > TWO_Q) || (ni < NTWO_Q);
      at_limit  = (k_ff == KW'(MAX_ITER));
      hit_idx   = k_ff - KW'(1);
      priority if (esc_sum) begin
         fin_idx = hit_idx;
      end else if (at_limit) begin
         fin_idx = '0;
      end else begin
         fin_idx = k_ff;
      end
   end

   assign status.done = esc_sum || at_limit || esc_range;

   always_ff @(posedge clock) begin
      if (cmd.map) begin
         cr_ff <= sat_point(origin_re_ff, col_prod_ff);
         ci_ff <= sat_point(origin_im_ff, row_prod_ff);
         zr_ff <= '0;
         zi_ff <= '0;
         k_ff  <= '0;
      end else if (cmd.add && !status.done) begin
         zr_ff <= nr[31:0];
         zi_ff <= ni[31:0];
         k_ff  <= k_ff + KW'(1);
      end
      if (cmd.mul) begin
         prr_ff <= zr_ff * zr_ff;
         pii_ff <= zi_ff * zi_ff;
         pri_ff <= zr_ff * zi_ff;
      end
      if (cmd.add && status.done) begin
         res_ff <= (32'(fin_idx) > 32'(mbe_pkg::COUNT_MAX)) ? mbe_pkg::COUNT_MAX
                                                            : mbe_pkg::COUNT_W'(fin_idx);
      end
   end

   // output register
   logic [mbe_pkg::SHADE_W-1:0] res_shade;

   assign res_shade = mbe_pkg::shade_of(res_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         escape_count <= res_ff;
         shade_level  <= res_shade;
         glyph        <= (res_ff == '0) ? mbe_pkg::GLYPH_SPACE
                                        : mbe_pkg::SHADE_GLYPHS[res_shade];
      end
   end

endmodule

// ----- src/mandelbrot_escape_time_pixel.sv -----
// Mandelbrot escape-time evaluator for one pixel at a time.
// req_ch carries a pixel (pixel_col, pixel_row); the point c is
// origin + pixel * step per axis, saturated to signed Q4.28. rsp_ch returns
// escape_count (round in which |z|^2 first exceeds 4, zero if never),
// shade_level = floor(log2(escape_count)) and an ASCII glyph for that shade
// (space for a zero count).
// The csr port writes origin_re, origin_im, step_re, step_im (indexes 0..3);
// write only while no pixel is in flight.
// Steps: the accept state, the mapping state, then per round of z*z + c a
// multiply state and an add state with the escape test, then the finish
// state, which loads the output register. A pixel runs P rounds, where P
// is the escape round plus one (plus two when the |z|^2 test fires, as it
// is checked a round late) and MAX_ITER + 1 for a point that never escapes.
// The pace is set by the round loop through the three 32x32 multipliers;
// one pixel is worked on at a time.
// A finished result sits in the output register; the next pixel is
// accepted while it waits. If the receiver stalls longer, the following
// result holds in the datapath until the register frees up.
// Reset clears the control state and restores the default view registers.
module mandelbrot_escape_time_pixel #(
   parameter int MAX_ITER   = mbe_pkg::MAX_ITER_DEF,
   parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mbe_req_if.sink                       req_ch,
   mbe_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [mbe_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [mbe_pkg::CFG_W-1:0]     csr_wdata
);

   mbe_pkg::cmd_type    cmd;
   mbe_pkg::status_type status;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_dpath #(
      .MAX_ITER   (MAX_ITER),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_idx      (csr_idx),
      .csr_wdata    (csr_wdata),
      .pixel_col    (req_ch.pixel_col),
      .pixel_row    (req_ch.pixel_row),
      .cmd          (cmd),
      .status       (status),
      .escape_count (rsp_ch.escape_count),
      .shade_level  (rsp_ch.shade_level),
      .glyph        (rsp_ch.glyph)
   );

endmodule

// ----- src/mbe_checker.sv -----
module mbe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mbe_pkg::COUNT_W-1:0]  escape_count,
   input logic [mbe_pkg::SHADE_W-1:0]  shade_level,
   input logic [mbe_pkg::GLYPH_W-1:0]  glyph
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(escape_count)
                                 && $stable(shade_level) && $stable(glyph))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while a pixel is in flight");

   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && escape_count == '0 |->
         shade_level == '0 && glyph == mbe_pkg::GLYPH_SPACE)
      else $error("zero count without blank shade");

   a_shade_log2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && escape_count != '0 |->
         (escape_count >> shade_level) == mbe_pkg::COUNT_W'(1))
      else $error("shade level is not floor log2 of count");

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .escape_count (rsp_ch.escape_count),
   .shade_level  (rsp_ch.shade_level),
   .glyph        (rsp_ch.glyph)
);
